// ===== rtl/e2cal_pkg.sv =====
// Shared types, constants and calendar helpers for the epoch to calendar date converter.
// No dependencies; every other file of the block imports this package.
package e2cal_pkg;

   localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
   // 2^32 nanoseconds are four whole seconds plus this many nanoseconds.
   localparam logic [28:0] FOLD_REM      = 29'd294967296;
   // Reciprocals of 675, 3600 and 60 scaled by 2^38, 2^29 and 2^18 and rounded up. Each one
   // gives the exact quotient over the range of values that reaches it.
   localparam logic [28:0] DAY_RECIP     = 29'd407226529;
   localparam logic [17:0] HOUR_RECIP    = 18'd149131;
   localparam logic [12:0] MIN_RECIP     = 13'd4370;
   localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
   localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
   localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
   localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
   localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
   localparam logic [8:0]  LAST_MOD400   = 9'd399;
   localparam logic [8:0]  DAYS_LEAP     = 9'd366;
   localparam logic [8:0]  DAYS_COMMON   = 9'd365;
   localparam logic [3:0]  MONTH_FEB     = 4'd1;
   localparam logic [3:0]  MONTH_DEC     = 4'd11;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FOLD,
      ST_FIX,
      ST_DAY_QUO,
      ST_DAY_REM,
      ST_HOUR_QUO,
      ST_HOUR_REM,
      ST_MIN_QUO,
      ST_MIN_REM,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic fold_step;
      logic fix_step;
      logic day_quo;
      logic day_rem;
      logic hour_quo;
      logic hour_rem;
      logic min_quo;
      logic min_rem;
      logic year_step;
      logic month_step;
   } cmd_type;

   typedef struct packed {
      logic fold_done;
      logic fix_done;
      logic year_fit;
      logic month_fit;
   } status_type;

   // The year modulo 400 settles the full Gregorian rule; its low two bits are the year modulo 4.
   function automatic logic is_leap(input logic [8:0] mod400);
      logic leap;
      if (mod400 == 9'd0) begin
         leap = 1'b1;
      end else if (mod400 == 9'd100 || mod400 == 9'd200 || mod400 == 9'd300) begin
         leap = 1'b0;
      end else begin
         leap = (mod400[1:0] == 2'd0);
      end
      return leap;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      unique case (month)
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd30;
         4'd5:    len = 5'd30;
         4'd8:    len = 5'd30;
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== rtl/epoch_ns_to_calendar_date.sv =====
// Converts nanoseconds since the Unix epoch into a Gregorian date and time of day.
// It splits off whole seconds, then days, hours and minutes, and then steps through the years after
// 1970 and the months in two loops.
// One item at a time; the next item is taken at the earliest in the cycle after the result is accepted.
// Reset is synchronous and active high; it returns the controller to idle.
// Depends on e2cal_pkg, e2cal_ctrl and e2cal_dp.
module epoch_ns_to_calendar_date
   import e2cal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_ns_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out,
   output logic [29:0] rsp_nanos_out
);

   cmd_type    cmd;
   status_type status;

   e2cal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   e2cal_dp u_dp (
      .clock          (clock),
      .req_ns_time    (req_ns_time),
      .cmd            (cmd),
      .status         (status),
      .rsp_year_out   (rsp_year_out),
      .rsp_month_out  (rsp_month_out),
      .rsp_day_out    (rsp_day_out),
      .rsp_hour_out   (rsp_hour_out),
      .rsp_minute_out (rsp_minute_out),
      .rsp_second_out (rsp_second_out),
      .rsp_nanos_out  (rsp_nanos_out)
   );

   // An accepted item cannot produce its result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result shown right after an item was accepted");

   // The block never takes an item while a result is still pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result is pending");

   // A finished date has a real month and day and a time of day in range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_out != 4'd0) && (rsp_month_out < 4'd13) &&
                    (rsp_day_out != 5'd0) && (rsp_hour_out < 5'd24))
      else $error("calendar field out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_minute_out < 6'd60) && (rsp_second_out < 6'd60) &&
                    (rsp_nanos_out < 30'd1000000000))
      else $error("time of day field out of range");

endmodule

// ===== rtl/e2cal_ctrl.sv =====
// Controller of the converter: sequences the seconds split, the time of day steps,
// the year loop and the month loop. Depends on e2cal_pkg for the state, command and status types.
module e2cal_ctrl
   import e2cal_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_FOLD;
         ST_FOLD:     if (status.fold_done) state_in = ST_FIX;
         ST_FIX:      if (status.fix_done) state_in = ST_DAY_QUO;
         ST_DAY_QUO:  state_in = ST_DAY_REM;
         ST_DAY_REM:  state_in = ST_HOUR_QUO;
         ST_HOUR_QUO: state_in = ST_HOUR_REM;
         ST_HOUR_REM: state_in = ST_MIN_QUO;
         ST_MIN_QUO:  state_in = ST_MIN_REM;
         ST_MIN_REM:  state_in = ST_YEAR;
         ST_YEAR:     if (status.year_fit) state_in = ST_MONTH;
         ST_MONTH:    if (status.month_fit) state_in = ST_DONE;
         ST_DONE:     if (rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      rsp_valid      = (state_ff == ST_DONE);
      cmd.load       = (state_ff == ST_IDLE) && req_valid;
      cmd.fold_step  = (state_ff == ST_FOLD) && !status.fold_done;
      cmd.fix_step   = (state_ff == ST_FIX) && !status.fix_done;
      cmd.day_quo    = (state_ff == ST_DAY_QUO);
      cmd.day_rem    = (state_ff == ST_DAY_REM);
      cmd.hour_quo   = (state_ff == ST_HOUR_QUO);
      cmd.hour_rem   = (state_ff == ST_HOUR_REM);
      cmd.min_quo    = (state_ff == ST_MIN_QUO);
      cmd.min_rem    = (state_ff == ST_MIN_REM);
      cmd.year_step  = (state_ff == ST_YEAR) && !status.year_fit;
      cmd.month_step = (state_ff == ST_MONTH) && !status.month_fit;
   end

endmodule

// ===== rtl/e2cal_dp.sv =====
// Datapath of the converter: folds the count into whole seconds, splits days and time of day
// by reciprocal multiplication, and runs the year and month subtraction loops. Depends on e2cal_pkg.
module e2cal_dp
   import e2cal_pkg::*;
(
   input  logic        clock,
   input  logic [63:0] req_ns_time,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [11:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out,
   output logic [29:0] rsp_nanos_out
);

   logic [63:0] val_ff, val_in;
   logic [34:0] secs_ff, secs_in;
   logic [17:0] days_ff, days_in;
   logic [16:0] sod_ff, sod_in;
   logic [4:0]  hour_ff, hour_in;
   logic [11:0] soh_ff, soh_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [11:0] year_ff, year_in;
   logic [8:0]  mod400_ff, mod400_in;
   logic [3:0]  month_ff, month_in;

   logic [60:0] fold_prod;
   logic [63:0] fold_sum;
   logic [56:0] day_prod;
   logic [34:0] day_back;
   logic [34:0] hour_prod;
   logic [16:0] hour_back;
   logic [24:0] min_prod;
   logic [11:0] min_back;
   logic        leap;
   logic [8:0]  year_len;
   logic [4:0]  mon_len;

   // Each fold moves the upper word into four seconds per unit plus the leftover nanoseconds,
   // so the nanosecond count shrinks until it fits 32 bits.
   assign fold_prod = {29'd0, val_ff[63:32]} * {32'd0, FOLD_REM};
   assign fold_sum  = {3'd0, fold_prod} + {32'd0, val_ff[31:0]};

   // The seconds are below 2^35, so shifting out 2^7 of 86400 leaves a 28-bit dividend for 675.
   assign day_prod  = {29'd0, secs_ff[34:7]} * {28'd0, DAY_RECIP};
   assign day_back  = {17'd0, days_ff} * {18'd0, SEC_PER_DAY};
   assign hour_prod = {18'd0, sod_ff} * {17'd0, HOUR_RECIP};
   assign hour_back = {12'd0, hour_ff} * {5'd0, SEC_PER_HOUR};
   assign min_prod  = {13'd0, soh_ff} * {12'd0, MIN_RECIP};
   assign min_back  = {6'd0, minute_ff} * {6'd0, SEC_PER_MIN};

   assign leap     = is_leap(mod400_ff);
   assign year_len = leap ? DAYS_LEAP : DAYS_COMMON;
   assign mon_len  = month_len(month_ff, leap && (month_ff == MONTH_FEB));

   assign status.fold_done = (val_ff[63:32] == 32'd0);
   assign status.fix_done  = (val_ff[31:0] < {2'b00, NS_PER_SEC});
   assign status.year_fit  = (days_ff < {9'd0, year_len});
   assign status.month_fit = (month_ff == MONTH_DEC) || (days_ff < {13'd0, mon_len});

   always_comb begin
      val_in    = val_ff;
      secs_in   = secs_ff;
      days_in   = days_ff;
      sod_in    = sod_ff;
      hour_in   = hour_ff;
      soh_in    = soh_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      year_in   = year_ff;
      mod400_in = mod400_ff;
      month_in  = month_ff;
      if (cmd.load) begin
         val_in    = req_ns_time;
         secs_in   = 35'd0;
         year_in   = EPOCH_YEAR;
         mod400_in = EPOCH_MOD400;
         month_in  = 4'd0;
      end
      if (cmd.fold_step) begin
         val_in  = fold_sum;
         secs_in = secs_ff + {1'b0, val_ff[63:32], 2'b00};
      end
      if (cmd.fix_step) begin
         val_in  = val_ff - {34'd0, NS_PER_SEC};
         secs_in = secs_ff + 35'd1;
      end
      // The remainders are known to fit their low bits, so only those are subtracted.
      if (cmd.day_quo) begin
         days_in = day_prod[55:38];
      end
      if (cmd.day_rem) begin
         sod_in = secs_ff[16:0] - day_back[16:0];
      end
      if (cmd.hour_quo) begin
         hour_in = hour_prod[33:29];
      end
      if (cmd.hour_rem) begin
         soh_in = sod_ff[11:0] - hour_back[11:0];
      end
      if (cmd.min_quo) begin
         minute_in = min_prod[23:18];
      end
      if (cmd.min_rem) begin
         second_in = soh_ff[5:0] - min_back[5:0];
      end
      if (cmd.year_step) begin
         days_in   = days_ff - {9'd0, year_len};
         year_in   = year_ff + 12'd1;
         mod400_in = (mod400_ff == LAST_MOD400) ? 9'd0 : mod400_ff + 9'd1;
      end
      if (cmd.month_step) begin
         days_in  = days_ff - {13'd0, mon_len};
         month_in = month_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      secs_ff   <= secs_in;
      days_ff   <= days_in;
      sod_ff    <= sod_in;
      hour_ff   <= hour_in;
      soh_ff    <= soh_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      year_ff   <= year_in;
      mod400_ff <= mod400_in;
      month_ff  <= month_in;
   end

   assign rsp_year_out   = year_ff;
   assign rsp_month_out  = month_ff + 4'd1;
   assign rsp_day_out    = days_ff[4:0] + 5'd1;
   assign rsp_hour_out   = hour_ff;
   assign rsp_minute_out = minute_ff;
   assign rsp_second_out = second_ff;
   assign rsp_nanos_out  = val_ff[29:0];

endmodule

// ===== dv/epoch_ns_to_calendar_date_test.sv =====
// Self-checking testbench for epoch_ns_to_calendar_date: directed dates, then random counts.
// Holds its own calendar predictor; needs only the RTL of the block and its package.
module epoch_ns_to_calendar_date_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [29:0] nanos;
   } calendar_date_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_ns_time;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [11:0] rsp_year_out;
   logic [3:0]  rsp_month_out;
   logic [4:0]  rsp_day_out;
   logic [4:0]  rsp_hour_out;
   logic [5:0]  rsp_minute_out;
   logic [5:0]  rsp_second_out;
   logic [29:0] rsp_nanos_out;

   calendar_date_type expected_dates[$];
   int unsigned       error_count = 0;
   bit                gap_enable = 1'b1;
   bit                stall_enable = 1'b1;

   epoch_ns_to_calendar_date dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ns_time    (req_ns_time),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_year_out   (rsp_year_out),
      .rsp_month_out  (rsp_month_out),
      .rsp_day_out    (rsp_day_out),
      .rsp_hour_out   (rsp_hour_out),
      .rsp_minute_out (rsp_minute_out),
      .rsp_second_out (rsp_second_out),
      .rsp_nanos_out  (rsp_nanos_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit leap_year(int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   function automatic int unsigned month_days(int unsigned y, int unsigned m);
      case (m)
         2:          return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:    return 31;
      endcase
   endfunction

   // Splits a nanosecond count into the calendar date and time of day it names.
   function automatic calendar_date_type calendar_of(logic [63:0] ns);
      calendar_date_type date;
      longint unsigned   secs;
      longint unsigned   days;
      longint unsigned   sec_of_day;
      int unsigned       y;
      int unsigned       m;
      secs       = ns / 64'd1000000000;
      date.nanos = 30'(ns % 64'd1000000000);
      days       = secs / 86400;
      sec_of_day = secs % 86400;
      date.hour   = 5'(sec_of_day / 3600);
      date.minute = 6'((sec_of_day % 3600) / 60);
      date.second = 6'(sec_of_day % 60);
      y = 1970;
      while (days >= (leap_year(y) ? 366 : 365)) begin
         days -= leap_year(y) ? 366 : 365;
         y++;
      end
      m = 1;
      while (m < 12 && days >= month_days(y, m)) begin
         days -= month_days(y, m);
         m++;
      end
      date.year  = 12'(y);
      date.month = 4'(m);
      date.day   = 5'(days + 1);
      return date;
   endfunction

   // Nanosecond count of a given calendar date and time of day.
   function automatic logic [63:0] ns_at(int unsigned y, int unsigned mo, int unsigned d,
                                        int unsigned h, int unsigned mi, int unsigned s,
                                        longint unsigned frac);
      longint unsigned days;
      days = 0;
      for (int unsigned i = 1970; i < y; i++) days += leap_year(i) ? 366 : 365;
      for (int unsigned i = 1; i < mo; i++) days += month_days(y, i);
      days += d - 1;
      return (days * 86400 + h * 3600 + mi * 60 + s) * 64'd1000000000 + frac;
   endfunction

   // Presents one item and returns at the edge where it is taken; valid is left high.
   task automatic send_time(input logic [63:0] t);
      int unsigned gap;
      if (gap_enable && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_ns_time <= t;
      expected_dates.push_back(calendar_of(t));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_dates.size() != 0);
   endtask

   task automatic test_directed();
      send_time(64'd0);
      send_time(64'hFFFF_FFFF_FFFF_FFFF);
      send_time(64'h8000_0000_0000_0000);
      send_time(64'h0000_0000_FFFF_FFFF);
      send_time(64'd999_999_999);
      send_time(ns_at(1970, 1, 1, 23, 59, 59, 999_999_999));
      send_time(ns_at(1970, 12, 31, 23, 59, 59, 999_999_999));
      send_time(ns_at(1971, 1, 1, 0, 0, 0, 0));
      send_time(ns_at(1972, 2, 29, 12, 30, 30, 500));
      send_time(ns_at(1972, 12, 31, 0, 0, 0, 0));
      // Century years: 2000 and 2400 are leap, 2100 is not.
      send_time(ns_at(2000, 2, 29, 23, 59, 59, 999_999_999));
      send_time(ns_at(2000, 3, 1, 0, 0, 0, 0));
      send_time(ns_at(2100, 2, 28, 23, 59, 59, 999_999_999));
      send_time(ns_at(2100, 3, 1, 0, 0, 0, 0));
      send_time(ns_at(2400, 2, 29, 6, 7, 8, 9));
      for (int unsigned m = 1; m <= 12; m++) begin
         send_time(ns_at(2024, m, month_days(2024, m), 23, 59, 59, 999_999_999));
      end
   endtask

   task automatic test_random_wide();
      for (int i = 0; i < 200; i++) send_time({$urandom(), $urandom()});
   endtask

   // Valid dates only, with the first and last nanosecond of a month weighted up.
   task automatic test_calendar_dates();
      int unsigned y;
      int unsigned m;
      int unsigned d;
      for (int i = 0; i < 200; i++) begin
         if (i == 100) wait_for_results();
         y = $urandom_range(1970, 2553);
         m = $urandom_range(1, 12);
         d = $urandom_range(1, month_days(y, m));
         case ($urandom_range(0, 3))
            0: send_time(ns_at(y, m, month_days(y, m), 23, 59, 59, 999_999_999));
            1: send_time(ns_at(y, m, 1, 0, 0, 0, 0));
            default: send_time(ns_at(y, m, d, $urandom_range(0, 23), $urandom_range(0, 59),
                                     $urandom_range(0, 59), $urandom_range(0, 999_999_999)));
         endcase
      end
   endtask

   task automatic test_short_counts();
      logic [63:0] t;
      for (int i = 0; i < 80; i++) begin
         t = {$urandom(), $urandom()};
         send_time(t >> $urandom_range(0, 63));
      end
   endtask

   task automatic test_back_to_back();
      gap_enable   = 1'b0;
      stall_enable = 1'b0;
      for (int i = 0; i < 80; i++) send_time({$urandom(), $urandom()});
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_enable && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      calendar_date_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_dates.size() == 0) begin
            $error("result arrived with no item outstanding");
            error_count++;
         end else begin
            want = expected_dates.pop_front();
            check_field("year_out", 64'(want.year), 64'(rsp_year_out));
            check_field("month_out", 64'(want.month), 64'(rsp_month_out));
            check_field("day_out", 64'(want.day), 64'(rsp_day_out));
            check_field("hour_out", 64'(want.hour), 64'(rsp_hour_out));
            check_field("minute_out", 64'(want.minute), 64'(rsp_minute_out));
            check_field("second_out", 64'(want.second), 64'(rsp_second_out));
            check_field("nanos_out", 64'(want.nanos), 64'(rsp_nanos_out));
         end
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_ns_time <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_wide();
      test_calendar_dates();
      test_short_counts();
      test_back_to_back();
      wait_for_results();
      // Any stray result shows up before this wait ends.
      repeat (900) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
